[rtl/gfe_pkg.sv]
// Shared types and constants of the gap-filling EWMA smoother.
// Used by the serial divider, the serial EWMA multiplier and the top level.
package gfe_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int TREND_W    = 32;
   localparam int ALPHA_W    = 16;
   localparam int STEP_CNT_W = $clog2(SAMPLE_W);

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;

   typedef struct packed {
      logic                start_series;
      logic [SAMPLE_W-1:0] day_number;
      logic [SAMPLE_W-1:0] sample_value;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] out_day;
      logic [SAMPLE_W-1:0] point_value;
      logic [SAMPLE_W-1:0] trend_value;
      logic                is_filled;
      logic                gap_overflow;
      logic                last_of_run;
   } rsp_type;

   typedef struct packed {
      logic                done;
      logic [SAMPLE_W-1:0] quo;
   } div_status_type;

   typedef struct packed {
      logic               done;
      logic [TREND_W-1:0] trend;
   } mul_status_type;

endpackage

[rtl/gap_filling_ewma_smoother.sv]
// Top level of the gap-filling EWMA smoother: sequencer, series state, result register.
// Depends on gfe_pkg, gfe_divider and gfe_ewma_mul.
//
//   channel  ports                          direction  carries
//   req      req_valid/req_ready/req_data   in         one day-stamped sample
//   rsp      rsp_valid/rsp_ready/rsp_data   out        one emitted point and trend
//   csr      csr_valid/csr_ready/csr_data   in         smoothing factor (Q0.16)
//
// A sample with no fill takes one pass through the 16-step serial EWMA unit; the input
// reopens once its result is loaded into the output register.
// A gap of g days (2 to MAX_GAP) adds a serial divide, then one EWMA pass a point:
// the g - 1 filled points leave first, the real point last, and the input reopens after it.
// Reset clears the series state and loads the default smoothing factor.
// A result waits in the output register; the sequencer stalls only when it must reload it.
module gap_filling_ewma_smoother #(
   parameter int MAX_GAP = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  gfe_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output gfe_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [gfe_pkg::ALPHA_W-1:0]  csr_data
);

   localparam int GAP_W = $clog2(MAX_GAP + 1);
   localparam int SW    = gfe_pkg::SAMPLE_W;
   localparam int TW    = gfe_pkg::TREND_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_MUL  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [gfe_pkg::ALPHA_W-1:0] alpha_ff, alpha_in;
   logic                       active_ff, active_in;
   logic [SW-1:0]              prev_day_ff, prev_day_in;
   logic [SW-1:0]              prev_smp_ff, prev_smp_in;
   logic [TW-1:0]              trend_ff, trend_in;
   logic [SW-1:0]              day_ff, day_in;
   logic [SW-1:0]              cur_ff, cur_in;
   logic                       ovf_ff, ovf_in;
   logic                       neg_ff, neg_in;
   logic [GAP_W-1:0]           gap_ff, gap_in;
   logic [GAP_W-1:0]           d_ff, d_in;
   logic [SW-1:0]              q_ff, q_in;
   logic [GAP_W-1:0]           r_ff, r_in;
   logic [SW-1:0]              qstep_ff, qstep_in;
   logic [GAP_W-1:0]           rstep_ff, rstep_in;
   logic [SW-1:0]              pt_ff, pt_in;
   logic [SW-1:0]              pt_day_ff, pt_day_in;
   logic                       pt_fill_ff, pt_fill_in;
   logic                       pt_last_ff, pt_last_in;
   logic                       div_go_ff, div_go_in;
   logic                       mul_go_ff, mul_go_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   gfe_pkg::rsp_type           out_ff, out_in;

   gfe_pkg::div_status_type    div_st;
   gfe_pkg::mul_status_type    mul_st;
   logic [GAP_W-1:0]           div_rem;
   logic [SW-1:0]              div_mag_ff, div_mag_in;

   logic                       seed;
   logic                       later;
   logic [SW-1:0]              gap_full;
   logic [SW:0]                diff_wide;
   logic                       out_free;
   logic [GAP_W-1:0]           d_next;
   logic [GAP_W:0]             r_sum;
   logic                       r_wrap;

   function automatic logic [SW-1:0] interp(input logic [SW-1:0] prev,
                                            input logic [SW-1:0] mag,
                                            input logic          neg);
      interp = neg ? prev - mag : prev + mag;
   endfunction

   assign seed      = req_data.start_series | ~active_ff;
   assign later     = req_data.day_number > prev_day_ff;
   assign gap_full  = req_data.day_number - prev_day_ff;
   assign diff_wide = {1'b0, req_data.sample_value} - {1'b0, prev_smp_ff};
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign d_next    = d_ff + 1'b1;
   assign r_sum     = {1'b0, r_ff} + {1'b0, rstep_ff};
   assign r_wrap    = r_sum >= {1'b0, gap_ff};

   always_comb begin
      state_in     = state_ff;
      alpha_in     = alpha_ff;
      active_in    = active_ff;
      prev_day_in  = prev_day_ff;
      prev_smp_in  = prev_smp_ff;
      trend_in     = trend_ff;
      day_in       = day_ff;
      cur_in       = cur_ff;
      ovf_in       = ovf_ff;
      neg_in       = neg_ff;
      gap_in       = gap_ff;
      d_in         = d_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      qstep_in     = qstep_ff;
      rstep_in     = rstep_ff;
      pt_in        = pt_ff;
      pt_day_in    = pt_day_ff;
      pt_fill_in   = pt_fill_ff;
      pt_last_in   = pt_last_ff;
      div_go_in    = 1'b0;
      mul_go_in    = 1'b0;
      div_mag_in   = div_mag_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      out_in       = out_ff;

      if (csr_valid) begin
         alpha_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               day_in     = req_data.day_number;
               cur_in     = req_data.sample_value;
               ovf_in     = ~seed & later & (gap_full > SW'(MAX_GAP));
               neg_in     = diff_wide[SW];
               gap_in     = gap_full[GAP_W-1:0];
               div_mag_in = diff_wide[SW] ? SW'(-diff_wide) : diff_wide[SW-1:0];
               if (seed) begin
                  trend_in = {req_data.sample_value, {(TW - SW){1'b0}}};
               end
               if (~seed & later & (gap_full <= SW'(MAX_GAP)) & (gap_full > SW'(1))) begin
                  div_go_in = 1'b1;
                  state_in  = S_DIV;
               end else begin
                  pt_in      = req_data.sample_value;
                  pt_day_in  = req_data.day_number;
                  pt_fill_in = 1'b0;
                  pt_last_in = 1'b1;
                  mul_go_in  = 1'b1;
                  state_in   = S_MUL;
               end
            end
         end
         S_DIV: begin
            if (div_st.done) begin
               // first filled day: quotient and remainder of |diff| / g
               qstep_in   = div_st.quo;
               rstep_in   = div_rem;
               q_in       = div_st.quo;
               r_in       = div_rem;
               d_in       = GAP_W'(1);
               pt_in      = interp(prev_smp_ff, div_st.quo, neg_ff);
               pt_day_in  = prev_day_ff + SW'(1);
               pt_fill_in = 1'b1;
               pt_last_in = 1'b0;
               mul_go_in  = 1'b1;
               state_in   = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_st.done) begin
               trend_in = mul_st.trend;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               out_in.out_day      = pt_day_ff;
               out_in.point_value  = pt_ff;
               out_in.trend_value  = trend_ff[TW-1:TW-SW];
               out_in.is_filled    = pt_fill_ff;
               out_in.gap_overflow = pt_last_ff & ovf_ff;
               out_in.last_of_run  = pt_last_ff;
               if (pt_last_ff) begin
                  active_in   = 1'b1;
                  prev_day_in = day_ff;
                  prev_smp_in = cur_ff;
                  state_in    = S_IDLE;
               end else begin
                  mul_go_in = 1'b1;
                  state_in  = S_MUL;
                  d_in      = d_next;
                  if (d_next == gap_ff) begin
                     pt_in      = cur_ff;
                     pt_day_in  = day_ff;
                     pt_fill_in = 1'b0;
                     pt_last_in = 1'b1;
                  end else begin
                     // advance |diff| * d / g by one step of quotient and remainder
                     if (r_wrap) begin
                        r_in = GAP_W'(r_sum - {1'b0, gap_ff});
                        q_in = q_ff + qstep_ff + SW'(1);
                     end else begin
                        r_in = r_sum[GAP_W-1:0];
                        q_in = q_ff + qstep_ff;
                     end
                     pt_in      = interp(prev_smp_ff, q_in, neg_ff);
                     pt_day_in  = prev_day_ff + SW'(d_next);
                     pt_fill_in = 1'b1;
                     pt_last_in = 1'b0;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         alpha_ff     <= gfe_pkg::ALPHA_RESET;
         active_ff    <= 1'b0;
         prev_day_ff  <= '0;
         prev_smp_ff  <= '0;
         trend_ff     <= '0;
         div_go_ff    <= 1'b0;
         mul_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alpha_ff     <= alpha_in;
         active_ff    <= active_in;
         prev_day_ff  <= prev_day_in;
         prev_smp_ff  <= prev_smp_in;
         trend_ff     <= trend_in;
         div_go_ff    <= div_go_in;
         mul_go_ff    <= mul_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      day_ff     <= day_in;
      cur_ff     <= cur_in;
      ovf_ff     <= ovf_in;
      neg_ff     <= neg_in;
      gap_ff     <= gap_in;
      d_ff       <= d_in;
      q_ff       <= q_in;
      r_ff       <= r_in;
      qstep_ff   <= qstep_in;
      rstep_ff   <= rstep_in;
      pt_ff      <= pt_in;
      pt_day_ff  <= pt_day_in;
      pt_fill_ff <= pt_fill_in;
      pt_last_ff <= pt_last_in;
      div_mag_ff <= div_mag_in;
      out_ff     <= out_in;
   end

   gfe_divider #(
      .DEN_W (GAP_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go_ff),
      .dividend  (div_mag_ff),
      .divisor   (gap_ff),
      .status    (div_st),
      .remainder (div_rem)
   );

   gfe_ewma_mul u_ewma_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_go_ff),
      .alpha  (alpha_ff),
      .point  (pt_ff),
      .trend  (trend_ff),
      .status (mul_st)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = out_ff;

   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_st.done |-> state_ff == S_MUL)
      else $error("EWMA unit finished outside its wait state");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> state_ff == S_DIV)
      else $error("divider finished outside its wait state");

   a_rem_below_gap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && pt_fill_ff) |-> r_ff < gap_ff)
      else $error("interpolation remainder not below the gap");

   a_fill_before_day: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_ff.is_filled) |-> (out_ff.out_day < day_ff && !out_ff.last_of_run))
      else $error("filled point not ahead of its real sample");

endmodule

[rtl/gfe_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle, one for each dividend bit.
// Depends on gfe_pkg for widths and the status struct.
module gfe_divider #(
   parameter int DEN_W = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gfe_pkg::SAMPLE_W-1:0]  dividend,
   input  logic [DEN_W-1:0]              divisor,
   output gfe_pkg::div_status_type       status,
   output logic [DEN_W-1:0]              remainder
);

   logic                            run_ff, run_in;
   logic                            done_ff, done_in;
   logic [gfe_pkg::STEP_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [gfe_pkg::SAMPLE_W-1:0]    quo_ff, quo_in;
   logic [DEN_W-1:0]                rem_ff, rem_in;
   logic [DEN_W-1:0]                den_ff, den_in;
   logic [DEN_W:0]                  trial;
   logic [DEN_W:0]                  diff;
   logic                            ge;

   assign trial = {rem_ff, quo_ff[gfe_pkg::SAMPLE_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (run_ff) begin
         // shift in the next dividend bit, subtract when it fits
         quo_in = {quo_ff[gfe_pkg::SAMPLE_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == gfe_pkg::STEP_CNT_W'(gfe_pkg::SAMPLE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.done = done_ff;
   assign status.quo  = quo_ff;
   assign remainder   = rem_ff;

endmodule

[rtl/gfe_ewma_mul.sv]
// Bit-serial EWMA update: trend + floor(alpha * ((point << 16) - trend) / 2^16),
// one alpha bit per cycle, lowest bit first. Depends on gfe_pkg.
module gfe_ewma_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [gfe_pkg::ALPHA_W-1:0]  alpha,
   input  logic [gfe_pkg::SAMPLE_W-1:0] point,
   input  logic [gfe_pkg::TREND_W-1:0]  trend,
   output gfe_pkg::mul_status_type      status
);

   localparam int DIFF_W = gfe_pkg::TREND_W + 1;
   localparam int ACC_W  = gfe_pkg::TREND_W + 2;

   logic                            run_ff, run_in;
   logic                            done_ff, done_in;
   logic [gfe_pkg::STEP_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [gfe_pkg::ALPHA_W-1:0]     a_sh_ff, a_sh_in;
   logic signed [DIFF_W-1:0]        diff_ff, diff_in;
   logic signed [ACC_W-1:0]         acc_ff, acc_in;
   logic [gfe_pkg::TREND_W-1:0]     base_ff, base_in;
   logic signed [ACC_W-1:0]         sum;
   logic [gfe_pkg::TREND_W-1:0]     x_word;

   assign x_word = {point, {(gfe_pkg::TREND_W - gfe_pkg::SAMPLE_W){1'b0}}};
   assign sum    = acc_ff + (a_sh_ff[0] ? ACC_W'(diff_ff) : ACC_W'(0));

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_sh_in = a_sh_ff;
      diff_in = diff_ff;
      acc_in  = acc_ff;
      base_in = base_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         a_sh_in = alpha;
         diff_in = $signed({1'b0, x_word}) - $signed({1'b0, trend});
         acc_in  = '0;
         base_in = trend;
      end else if (run_ff) begin
         // add on a set alpha bit, then halve with floor
         acc_in  = {sum[ACC_W-1], sum[ACC_W-1:1]};
         a_sh_in = a_sh_ff >> 1;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == gfe_pkg::STEP_CNT_W'(gfe_pkg::ALPHA_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      a_sh_ff <= a_sh_in;
      diff_ff <= diff_in;
      acc_ff  <= acc_in;
      base_ff <= base_in;
   end

   assign status.done  = done_ff;
   assign status.trend = base_ff + acc_ff[gfe_pkg::TREND_W-1:0];

endmodule

[verif/gap_filling_ewma_smoother_test.sv]
// Self-checking testbench for the gap-filling EWMA smoother.
// Predicts fill points and trend in-line and checks every result transfer.
// Depends on gfe_pkg and gap_filling_ewma_smoother.
module gap_filling_ewma_smoother_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GAP_LIMIT        = 64;
   localparam int CYCLE_LIMIT      = 2_000_000;
   localparam int SETTLE_CYCLES    = 40;
   localparam int LONG_HOLD_CYCLES = 800;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   gfe_pkg::req_type            req_data;
   logic                        rsp_valid;
   logic                        rsp_ready;
   gfe_pkg::rsp_type            rsp_data;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [gfe_pkg::ALPHA_W-1:0] csr_data;

   gap_filling_ewma_smoother #(
      .MAX_GAP(GAP_LIMIT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always #5 clock = ~clock;

   // predictor state, mirrors the block's series registers
   logic                        model_active;
   logic [15:0]                 model_prev_day;
   logic [15:0]                 model_prev_sample;
   logic [31:0]                 model_trend;
   logic [gfe_pkg::ALPHA_W-1:0] model_alpha;

   gfe_pkg::rsp_type pending_points[$];

   logic [15:0] last_day_sent;
   logic [15:0] last_value_sent;
   bit          sender_gaps_on;
   bit          receiver_stalls_on;
   bit          hold_off_request;

   int error_count;
   int items_sent;
   int points_checked;
   int filled_seen;
   int overflow_seen;
   int alpha_writes;
   int cycle_count;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic void advance_trend(input logic [15:0] point);
      logic [63:0] sum;
      sum = 64'(model_alpha) * {32'h0, point, 16'h0}
          + (64'd65536 - 64'(model_alpha)) * 64'(model_trend);
      model_trend = sum[47:16];
   endfunction

   function automatic void push_point(input logic [15:0] day, input logic [15:0] point,
                                      input logic filled, input logic ovf);
      gfe_pkg::rsp_type r;
      advance_trend(point);
      r.out_day      = day;
      r.point_value  = point;
      r.trend_value  = model_trend[31:16];
      r.is_filled    = filled;
      r.gap_overflow = ovf;
      r.last_of_run  = !filled;
      pending_points = {pending_points, r};
   endfunction

   function automatic void predict_points(input gfe_pkg::req_type item);
      int          diff;
      int          q;
      int unsigned g;
      logic        ovf;
      ovf = 1'b0;
      if (item.start_series || !model_active) begin
         model_trend = {item.sample_value, 16'h0};
      end else if (item.day_number > model_prev_day) begin
         g = item.day_number - model_prev_day;
         if (g > GAP_LIMIT) begin
            ovf = 1'b1;
         end else if (g > 1) begin
            diff = int'(item.sample_value) - int'(model_prev_sample);
            for (int d = 1; d < int'(g); d++) begin
               // signed divide truncates toward zero
               q = (diff * d) / int'(g);
               push_point(model_prev_day + 16'(d), 16'(int'(model_prev_sample) + q),
                          1'b1, 1'b0);
            end
         end
      end
      push_point(item.day_number, item.sample_value, 1'b0, ovf);
      model_active      = 1'b1;
      model_prev_day    = item.day_number;
      model_prev_sample = item.sample_value;
   endfunction

   task automatic send_sample(input logic start, input logic [15:0] day,
                              input logic [15:0] value);
      gfe_pkg::req_type item;
      item.start_series = start;
      item.day_number   = day;
      item.sample_value = value;
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_points(item);
      items_sent++;
      last_day_sent   = day;
      last_value_sent = value;
      if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic send_random_sample();
      int          kind;
      int unsigned next_day;
      logic [15:0] value;
      logic        start;
      kind  = $urandom_range(0, 99);
      start = 1'b0;
      if (kind < 6) begin
         start    = 1'b1;
         next_day = $urandom_range(0, 65535);
      end else if (kind < 12) begin
         // noise: same or earlier day
         next_day = (last_day_sent > 3) ? last_day_sent - $urandom_range(0, 3)
                                        : last_day_sent;
      end else if (kind < 22) begin
         next_day = last_day_sent + $urandom_range(9, GAP_LIMIT);
      end else if (kind < 26) begin
         next_day = last_day_sent + $urandom_range(GAP_LIMIT + 1, 400);
      end else begin
         next_day = last_day_sent + $urandom_range(1, 8);
      end
      // restart low when the day range runs out
      if (next_day > 65535) begin
         start    = 1'b1;
         next_day = $urandom_range(0, 1000);
      end
      if ($urandom_range(0, 3) == 0)
         value = 16'($urandom);
      else
         value = last_value_sent + 16'($urandom_range(0, 511)) - 16'd256;
      send_sample(start, next_day[15:0], value);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_alpha(input logic [gfe_pkg::ALPHA_W-1:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_alpha = value;
      alpha_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // reset alpha, first sample without start, flat, repeated and falling days, big gaps
   task automatic test_directed_days();
      send_sample(1'b0, 16'd100,   16'h1000);
      send_sample(1'b0, 16'd101,   16'h2000);
      send_sample(1'b0, 16'd101,   16'h3000);
      send_sample(1'b0, 16'd50,    16'hFFFF);
      send_sample(1'b0, 16'd53,    16'h0000);
      send_sample(1'b0, 16'd117,   16'hFFFF);
      send_sample(1'b0, 16'd182,   16'h0000);
      send_sample(1'b1, 16'hFFFF,  16'h8000);
      send_sample(1'b1, 16'd0,     16'h0001);
      send_sample(1'b0, 16'd64,    16'hFFFE);
      send_sample(1'b0, 16'hFFFF,  16'h1234);
      send_sample(1'b1, 16'd10,    16'h4000);
      send_sample(1'b0, 16'd20,    16'h3FF7);
      wait_for_drain();
   endtask

   task automatic test_alpha_extremes();
      logic [gfe_pkg::ALPHA_W-1:0] settings[3];
      settings = '{16'h0000, 16'hFFFF, 16'h8000};
      foreach (settings[i]) begin
         write_alpha(settings[i]);
         send_sample(1'b1, 16'd1000, 16'h0100);
         send_sample(1'b0, 16'd1005, 16'hF000);
         wait_for_drain();
      end
   endtask

   task automatic test_random_series();
      logic [gfe_pkg::ALPHA_W-1:0] setting;
      for (int phase = 0; phase < 3; phase++) begin
         setting = (phase == 1) ? 16'($urandom_range(0, 255)) : 16'($urandom);
         write_alpha(setting);
         repeat (40) send_random_sample();
         wait_for_drain();
      end
   endtask

   // receiver holds off while samples keep coming, so the input stalls
   task automatic test_output_backpressure();
      sender_gaps_on   = 1'b0;
      hold_off_request = 1'b1;
      repeat (15) send_random_sample();
      wait_for_drain();
      sender_gaps_on = 1'b1;
   endtask

   task automatic test_unthrottled_tail();
      sender_gaps_on     = 1'b0;
      receiver_stalls_on = 1'b0;
      write_alpha(gfe_pkg::ALPHA_RESET);
      repeat (30) send_random_sample();
      wait_for_drain();
   endtask

   initial begin : receiver
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            for (int n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clock);
         end else if (receiver_stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      gfe_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            report_mismatch("result with nothing pending, out_day", rsp_data.out_day, 0);
         end else begin
            want = pending_points.pop_front();
            points_checked++;
            if (want.is_filled) filled_seen++;
            if (want.gap_overflow) overflow_seen++;
            if (rsp_data.out_day !== want.out_day)
               report_mismatch("out_day", rsp_data.out_day, want.out_day);
            if (rsp_data.point_value !== want.point_value)
               report_mismatch("point_value", rsp_data.point_value, want.point_value);
            if (rsp_data.trend_value !== want.trend_value)
               report_mismatch("trend_value", rsp_data.trend_value, want.trend_value);
            if (rsp_data.is_filled !== want.is_filled)
               report_mismatch("is_filled", rsp_data.is_filled, want.is_filled);
            if (rsp_data.gap_overflow !== want.gap_overflow)
               report_mismatch("gap_overflow", rsp_data.gap_overflow, want.gap_overflow);
            if (rsp_data.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", rsp_data.last_of_run, want.last_of_run);
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("gap_filling_ewma_smoother regression: fail");
      $finish;
   end

   initial begin : sequencer
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      model_active      = 1'b0;
      model_prev_day    = '0;
      model_prev_sample = '0;
      model_trend       = '0;
      model_alpha       = gfe_pkg::ALPHA_RESET;
      last_day_sent      = '0;
      last_value_sent    = '0;
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b1;
      hold_off_request   = 1'b0;
      error_count    = 0;
      items_sent     = 0;
      points_checked = 0;
      filled_seen    = 0;
      overflow_seen  = 0;
      alpha_writes   = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_days();
      test_alpha_extremes();
      test_random_series();
      test_output_backpressure();
      test_unthrottled_tail();

      if (pending_points.size() != 0)
         report_mismatch("points never delivered", 0, pending_points.size());
      $display("covered %0d samples and %0d points (%0d filled, %0d past gap limit)",
               items_sent, points_checked, filled_seen, overflow_seen);
      $display("across reset alpha and %0d written alpha settings, %0d cycles",
               alpha_writes, cycle_count);
      if (error_count == 0) begin
         $display("gap_filling_ewma_smoother regression: pass");
      end else begin
         $display("gap_filling_ewma_smoother regression: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/gfe_pkg.sv
rtl/gfe_divider.sv
rtl/gfe_ewma_mul.sv
rtl/gap_filling_ewma_smoother.sv
verif/gap_filling_ewma_smoother_test.sv
